// ===== rtl/ycbcr_chroma_420_average_reconstruct_top_macros.svh =====
// Assertion macros shared by the checkers of the chroma block.
`ifndef YCBCR_CHROMA_420_AVERAGE_RECONSTRUCT_TOP_MACROS_SVH
`define YCBCR_CHROMA_420_AVERAGE_RECONSTRUCT_TOP_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define YCRA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ycra assertion failed");

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define YCRA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ycra assertion failed");

`endif

// ===== rtl/ycra_pkg.sv =====
package ycra_pkg;

    localparam int CFG_W = 12;
    localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = 12'd640;
    localparam logic [0:0] REG_LINE_WIDTH = 1'b0;

    // forward coefficients, Q16
    localparam logic [16:0] K_Y_R = 17'd19595;
    localparam logic [16:0] K_Y_G = 17'd38469;
    localparam logic [16:0] K_Y_B = 17'd7471;
    localparam logic signed [17:0] K_CB_R = -18'sd11058;
    localparam logic signed [17:0] K_CB_G = -18'sd21709;
    localparam logic signed [17:0] K_CB_B = 18'sd32768;
    localparam logic signed [17:0] K_CR_R = 18'sd32768;
    localparam logic signed [17:0] K_CR_G = -18'sd27439;
    localparam logic signed [17:0] K_CR_B = -18'sd5328;

    // inverse coefficients, Q16
    localparam logic signed [17:0] K_R_CR = 18'sd91881;
    localparam logic signed [17:0] K_G_CB = 18'sd22553;
    localparam logic signed [17:0] K_G_CR = 18'sd46801;
    localparam logic signed [17:0] K_B_CB = 18'sd116129;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_STORE,
        ACT_HOLD,
        ACT_EMIT
    } t_act;

    typedef struct packed {
        logic signed [8:0] cr;
        logic signed [8:0] cb;
        logic [7:0]        y;
    } t_ycc;

    // Q16 value to 0..255; floor and truncation agree once negatives clamp to 0
    function automatic logic [7:0] sat8(input logic signed [27:0] t);
        logic [7:0] res;
        if (t[27]) begin
            res = 8'd0;
        end else if (t[26:24] != 3'd0) begin
            res = 8'd255;
        end else begin
            res = t[23:16];
        end
        return res;
    endfunction

endpackage

// ===== rtl/ycra_if.sv =====
interface ycra_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       first_of_frame;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output first_of_frame, input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in,
                  input first_of_frame, output ready);
endinterface

interface ycra_out_if #(
    parameter int COL_W = 11
);
    logic             valid;
    logic             ready;
    logic [7:0]       red_out;
    logic [7:0]       green_out;
    logic [7:0]       blue_out;
    logic [COL_W-1:0] pixel_column;
    logic             lower_row;
    logic             last_of_block;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output pixel_column, output lower_row, output last_of_block,
                    input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  input pixel_column, input lower_row, input last_of_block,
                  output ready);
endinterface

// ===== rtl/ycra_ram.sv =====
module ycra_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/ycbcr_chroma_420_average_reconstruct_top.sv =====
// Order: the four words of a 2x2 block leave after the lower-right pixel is accepted,
// through the registers of the sums, line store read, chroma average and output.
// Throughput: 1 pixel per cycle on upper rows when nothing downstream stalls; on lower
// rows the rate is set by the single output port that carries 4 words per block.
// Reset (synchronous, active low): pipeline empty, counters and left hold zero,
// line_width 640; the line store keeps its contents and needs no clearing pass.
module ycbcr_chroma_420_average_reconstruct_top #(
    parameter int MAX_LINE_WIDTH = 2048
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ycra_in_if.sink           i_pix,
    ycra_out_if.source        o_pix,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import ycra_pkg::*;

    localparam int CW   = $clog2(MAX_LINE_WIDTH);
    localparam int WW   = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int AW   = CW - 1;
    localparam int HALF = (MAX_LINE_WIDTH + 1) / 2;

    // configuration
    logic [CFG_W-1:0] r_line_width;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        if (paddr[2] == REG_LINE_WIDTH) begin
            prdata = {{(32 - CFG_W){1'b0}}, r_line_width};
        end else begin
            prdata = '0;
        end
    end

    // row tracking
    logic [CW-1:0] r_col;
    logic          r_par;
    logic [WW-1:0] eff_w;
    logic [WW-1:0] span;
    logic [CW-1:0] cur_col;
    logic          cur_par;
    logic [WW-1:0] col_inc;
    logic [CW-1:0] n_col;
    logic          n_par;
    t_act          n_act;

    always_comb begin
        eff_w = WW'(r_line_width);
        if (eff_w < WW'(2)) begin
            eff_w = WW'(2);
        end
        if (eff_w > WW'(MAX_LINE_WIDTH)) begin
            eff_w = WW'(MAX_LINE_WIDTH);
        end
        span    = {eff_w[WW-1:1], 1'b0};
        cur_col = i_pix.first_of_frame ? '0 : r_col;
        cur_par = i_pix.first_of_frame ? 1'b0 : r_par;
        col_inc = WW'(cur_col) + WW'(1);
        if (WW'(cur_col) >= span) begin
            n_act = ACT_NONE;
        end else if (!cur_par) begin
            n_act = ACT_STORE;
        end else if (!cur_col[0]) begin
            n_act = ACT_HOLD;
        end else begin
            n_act = ACT_EMIT;
        end
        if (col_inc >= eff_w) begin
            n_col = '0;
            n_par = ~cur_par;
        end else begin
            n_col = CW'(col_inc);
            n_par = cur_par;
        end
    end

    // forward products
    logic [23:0]        n_y_sum;
    logic signed [26:0] n_cb_sum;
    logic signed [26:0] n_cr_sum;

    always_comb begin
        n_y_sum = K_Y_R * i_pix.red_in + K_Y_G * i_pix.green_in + K_Y_B * i_pix.blue_in;
        n_cb_sum = K_CB_R * $signed({1'b0, i_pix.red_in})
                 + K_CB_G * $signed({1'b0, i_pix.green_in})
                 + K_CB_B * $signed({1'b0, i_pix.blue_in});
        n_cr_sum = K_CR_R * $signed({1'b0, i_pix.red_in})
                 + K_CR_G * $signed({1'b0, i_pix.green_in})
                 + K_CR_B * $signed({1'b0, i_pix.blue_in});
    end

    // pipeline control
    logic r_a_v, r_b_v, r_c_v, r_o_v;
    logic a_adv, a_free, b_adv, b_free, c_step, c_free, o_free, in_acc;
    logic [1:0] r_c_cnt;

    t_act               r_a_act;
    logic [CW-1:0]      r_a_col;
    logic [23:0]        r_a_y_sum;
    logic signed [26:0] r_a_cb_sum;
    logic signed [26:0] r_a_cr_sum;

    assign o_free = ~r_o_v | o_pix.ready;
    assign c_step = r_c_v & o_free;
    assign c_free = ~r_c_v | (c_step & (r_c_cnt == 2'd3));
    assign b_adv  = r_b_v & c_free;
    assign b_free = ~r_b_v | c_free;
    assign a_adv  = r_a_v & ((r_a_act != ACT_EMIT) | b_free);
    assign a_free = ~r_a_v | a_adv;
    assign in_acc = i_pix.valid & a_free;
    assign i_pix.ready = a_free;

    // stage A: finish the forward conversion
    logic signed [26:0] cb_adj;
    logic signed [26:0] cr_adj;
    t_ycc               a_pix;

    always_comb begin
        cb_adj  = r_a_cb_sum + (r_a_cb_sum[26] ? 27'sd65535 : 27'sd0);
        cr_adj  = r_a_cr_sum + (r_a_cr_sum[26] ? 27'sd65535 : 27'sd0);
        a_pix.y  = r_a_y_sum[23:16];
        a_pix.cb = cb_adj[24:16];
        a_pix.cr = cr_adj[24:16];
    end

    // line store: even and odd columns in separate memories
    logic          a_wr_even, a_wr_odd, a_rd;
    logic [AW-1:0] a_addr;
    logic [25:0]   even_rd, odd_rd;
    t_ycc          r_left;

    assign a_addr    = r_a_col[CW-1:1];
    assign a_wr_even = a_adv & (r_a_act == ACT_STORE) & ~r_a_col[0];
    assign a_wr_odd  = a_adv & (r_a_act == ACT_STORE) & r_a_col[0];
    assign a_rd      = a_adv & (r_a_act == ACT_EMIT);

    ycra_ram #(.WIDTH(26), .DEPTH(HALF)) u_ram_even (
        .i_clk     (i_clk),
        .i_wr_en   (a_wr_even),
        .i_wr_addr (a_addr),
        .i_wr_data (a_pix),
        .i_rd_en   (a_rd),
        .i_rd_addr (a_addr),
        .o_rd_data (even_rd)
    );

    ycra_ram #(.WIDTH(26), .DEPTH(HALF)) u_ram_odd (
        .i_clk     (i_clk),
        .i_wr_en   (a_wr_odd),
        .i_wr_addr (a_addr),
        .i_wr_data (a_pix),
        .i_rd_en   (a_rd),
        .i_rd_addr (a_addr),
        .o_rd_data (odd_rd)
    );

    // stage B: chroma average over the block
    t_ycc               r_b_pix;
    t_ycc               r_b_left;
    logic [CW-1:0]      r_b_col;
    t_ycc               ul, ur;
    logic signed [10:0] sum_cb, sum_cr, adj_cb, adj_cr;

    always_comb begin
        ul = even_rd;
        ur = odd_rd;
        sum_cb = 11'($signed(ul.cb)) + 11'($signed(ur.cb))
               + 11'($signed(r_b_left.cb)) + 11'($signed(r_b_pix.cb));
        sum_cr = 11'($signed(ul.cr)) + 11'($signed(ur.cr))
               + 11'($signed(r_b_left.cr)) + 11'($signed(r_b_pix.cr));
        adj_cb = sum_cb + (sum_cb[10] ? 11'sd3 : 11'sd0);
        adj_cr = sum_cr + (sum_cr[10] ? 11'sd3 : 11'sd0);
    end

    // stage C: rebuild one word per cycle while the output register can take it
    logic [7:0]         r_c_y [4];
    logic signed [8:0]  r_c_cb;
    logic signed [8:0]  r_c_cr;
    logic [CW-1:0]      r_c_col;
    logic [7:0]         y_cur;
    logic signed [27:0] y_sh, t_r, t_g, t_b;

    always_comb begin
        y_cur = r_c_y[r_c_cnt];
        y_sh  = $signed({4'b0, y_cur, 16'b0});
        t_r   = y_sh + r_c_cr * K_R_CR;
        t_g   = y_sh - r_c_cb * K_G_CB - r_c_cr * K_G_CR;
        t_b   = y_sh + r_c_cb * K_B_CB;
    end

    // output register
    logic [7:0]    r_o_red, r_o_green, r_o_blue;
    logic [CW-1:0] r_o_col;
    logic          r_o_lower, r_o_last;

    assign o_pix.valid         = r_o_v;
    assign o_pix.red_out       = r_o_red;
    assign o_pix.green_out     = r_o_green;
    assign o_pix.blue_out      = r_o_blue;
    assign o_pix.pixel_column  = r_o_col;
    assign o_pix.lower_row     = r_o_lower;
    assign o_pix.last_of_block = r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RESET;
            r_col        <= '0;
            r_par        <= 1'b0;
            r_left       <= '0;
            r_a_v        <= 1'b0;
            r_b_v        <= 1'b0;
            r_c_v        <= 1'b0;
            r_c_cnt      <= '0;
            r_o_v        <= 1'b0;
        end else begin
            if (cfg_wr && paddr[2] == REG_LINE_WIDTH) begin
                r_line_width <= pwdata[CFG_W-1:0];
            end
            if (in_acc) begin
                r_col <= n_col;
                r_par <= n_par;
            end
            if (a_adv && r_a_act == ACT_HOLD) begin
                r_left <= a_pix;
            end
            if (a_free) begin
                r_a_v <= in_acc;
            end
            if (b_free) begin
                r_b_v <= a_rd;
            end
            if (b_adv) begin
                r_c_v   <= 1'b1;
                r_c_cnt <= '0;
            end else if (c_step) begin
                r_c_cnt <= r_c_cnt + 2'd1;
                if (r_c_cnt == 2'd3) begin
                    r_c_v <= 1'b0;
                end
            end
            if (o_free) begin
                r_o_v <= c_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_act    <= n_act;
            r_a_col    <= cur_col;
            r_a_y_sum  <= n_y_sum;
            r_a_cb_sum <= n_cb_sum;
            r_a_cr_sum <= n_cr_sum;
        end
        if (a_rd) begin
            r_b_pix  <= a_pix;
            r_b_left <= r_left;
            r_b_col  <= r_a_col;
        end
        if (b_adv) begin
            r_c_y[0] <= ul.y;
            r_c_y[1] <= ur.y;
            r_c_y[2] <= r_b_left.y;
            r_c_y[3] <= r_b_pix.y;
            r_c_cb   <= adj_cb[10:2];
            r_c_cr   <= adj_cr[10:2];
            r_c_col  <= r_b_col;
        end
        if (c_step) begin
            r_o_red   <= sat8(t_r);
            r_o_green <= sat8(t_g);
            r_o_blue  <= sat8(t_b);
            r_o_col   <= {r_c_col[CW-1:1], r_c_cnt[0]};
            r_o_lower <= r_c_cnt[1];
            r_o_last  <= (r_c_cnt == 2'd3);
        end
    end

endmodule

// ===== rtl/ycra_chk.sv =====
`include "ycbcr_chroma_420_average_reconstruct_top_macros.svh"

module ycra_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic i_ready,
    input logic i_lower,
    input logic i_last,
    input logic i_col0
);

    // hold a stalled word
    `YCRA_ASSERT_NXT(a_stall_hold, i_valid && !i_ready, i_valid && $stable(i_col0))
    // close a block on its lower-right pixel
    `YCRA_ASSERT_IMP(a_last_lower, i_valid && i_last, i_lower && i_col0)
    // advance a block without gaps
    `YCRA_ASSERT_NXT(a_block_burst, i_valid && i_ready && !i_last, i_valid)

endmodule

bind ycbcr_chroma_420_average_reconstruct_top ycra_chk u_ycra_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_pix.valid),
    .i_ready (o_pix.ready),
    .i_lower (o_pix.lower_row),
    .i_last  (o_pix.last_of_block),
    .i_col0  (o_pix.pixel_column[0])
);

// ===== dv/ycbcr_chroma_420_average_reconstruct_top_tb.sv =====
module ycbcr_chroma_420_average_reconstruct_top_tb;
    import ycra_pkg::*;

    localparam int MAX_W = 2048;
    localparam logic [2:0] LINE_WIDTH_ADDR = {REG_LINE_WIDTH, 2'b00};
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 140;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_start;
    } t_pixel;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [10:0] column;
        logic        lower_row;
        logic        block_end;
    } t_rgb_word;

    class chroma_scoreboard;
        t_ycc        row_store [MAX_W];
        t_ycc        left_hold;
        int unsigned col_cnt;
        bit          odd_row;
        logic [11:0] width_reg;
        t_rgb_word   expected_q [$];
        int          errors;

        function new();
            width_reg = LINE_WIDTH_RESET;
            left_hold = '0;
            col_cnt = 0;
            odd_row = 1'b0;
            errors = 0;
        endfunction

        static function int eff_width(logic [11:0] w);
            if (w < 2) begin
                return 2;
            end
            if (w > MAX_W) begin
                return MAX_W;
            end
            return int'(w);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void set_width(logic [11:0] w);
            width_reg = w;
        endfunction

        function void add_expected(t_rgb_word wd);
            expected_q.insert(expected_q.size(), wd);
        endfunction

        function t_ycc to_ycc(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            longint ri, gi, bi, y, cb, cr;
            t_ycc p;
            ri = r;
            gi = g;
            bi = b;
            y = (ri * 19595 + gi * 38469 + bi * 7471) / 65536;
            cb = (ri * (-11058) + gi * (-21709) + bi * 32768) / 65536;
            cr = (ri * 32768 + gi * (-27439) + bi * (-5328)) / 65536;
            p.y = y[7:0];
            p.cb = cb[8:0];
            p.cr = cr[8:0];
            return p;
        endfunction

        function logic [7:0] clamp8(longint v);
            if (v < 0) begin
                return 8'd0;
            end
            if (v > 255) begin
                return 8'd255;
            end
            return v[7:0];
        endfunction

        function t_rgb_word rebuild(t_ycc p, int cb, int cr, int unsigned col, bit lower,
                                    bit block_end);
            longint yq;
            t_rgb_word wd;
            yq = longint'(p.y) * 65536;
            wd.red = clamp8((yq + longint'(cr) * 91881) / 65536);
            wd.green = clamp8((yq - longint'(cb) * 22553 - longint'(cr) * 46801) / 65536);
            wd.blue = clamp8((yq + longint'(cb) * 116129) / 65536);
            wd.column = col[10:0];
            wd.lower_row = lower;
            wd.block_end = block_end;
            return wd;
        endfunction

        function void note_pixel(t_pixel px);
            int w;
            int unsigned c, span;
            t_ycc p, ul, ur;
            int cb, cr;
            w = eff_width(width_reg);
            span = w & ~1;
            if (px.frame_start) begin
                col_cnt = 0;
                odd_row = 1'b0;
            end
            c = col_cnt;
            p = to_ycc(px.red, px.green, px.blue);
            if (c < span) begin
                if (!odd_row) begin
                    row_store[c] = p;
                end else if (c[0] == 1'b0) begin
                    left_hold = p;
                end else begin
                    ul = row_store[c - 1];
                    ur = row_store[c];
                    cb = (int'(ul.cb) + int'(ur.cb) + int'(left_hold.cb) + int'(p.cb)) / 4;
                    cr = (int'(ul.cr) + int'(ur.cr) + int'(left_hold.cr) + int'(p.cr)) / 4;
                    add_expected(rebuild(ul, cb, cr, c - 1, 1'b0, 1'b0));
                    add_expected(rebuild(ur, cb, cr, c, 1'b0, 1'b0));
                    add_expected(rebuild(left_hold, cb, cr, c - 1, 1'b1, 1'b0));
                    add_expected(rebuild(p, cb, cr, c, 1'b1, 1'b1));
                end
            end
            if (c + 1 >= w) begin
                col_cnt = 0;
                odd_row = ~odd_row;
            end else begin
                col_cnt = c + 1;
            end
        endfunction

        function void compare_field(string name, logic [11:0] exp_v, logic [11:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            end
        endfunction

        function void check_word(t_rgb_word act);
            t_rgb_word exp_w;
            if (expected_q.size() == 0) begin
                errors++;
                $error("word with nothing pending, column %0d", act.column);
                return;
            end
            exp_w = expected_q.pop_front();
            compare_field("red_out", exp_w.red, act.red);
            compare_field("green_out", exp_w.green, act.green);
            compare_field("blue_out", exp_w.blue, act.blue);
            compare_field("pixel_column", exp_w.column, act.column);
            compare_field("lower_row", exp_w.lower_row, act.lower_row);
            compare_field("last_of_block", exp_w.block_end, act.block_end);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ycra_in_if                 pix_in ();
    ycra_out_if #(.COL_W(11))  pix_out ();

    chroma_scoreboard sb = new();
    t_pixel           pixel_q [$];
    int               cur_eff = 640;
    bit               width_grew;
    bit               hold_req;
    int               idle_cycles = 0;

    ycbcr_chroma_420_average_reconstruct_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        t_pixel    px;
        t_rgb_word wd;
        bit        in_acc, out_acc;
        if (i_rst_n) begin
            in_acc = pix_in.valid && pix_in.ready;
            out_acc = pix_out.valid && pix_out.ready;
            if (in_acc) begin
                px = {pix_in.red_in, pix_in.green_in, pix_in.blue_in, pix_in.first_of_frame};
                sb.note_pixel(px);
            end
            if (out_acc) begin
                wd = {pix_out.red_out, pix_out.green_out, pix_out.blue_out,
                      pix_out.pixel_column, pix_out.lower_row, pix_out.last_of_block};
                sb.check_word(wd);
            end
            if (in_acc || out_acc) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int stall_pct, pat_left;
        stall_pct = 0;
        pat_left = 0;
        pix_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                pix_out.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (pat_left == 0) begin
                    pat_left = $urandom_range(8, 64);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 30;
                        2: stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                end
                pat_left--;
                pix_out.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    function automatic logic [7:0] rand_level();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void push_pix(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit fof);
        pixel_q.insert(pixel_q.size(), {r, g, b, fof});
    endfunction

    // pairs == 0: a broken run of random length and frame starts
    function automatic void build_frame(int pairs, int noise_pct);
        int n;
        bit fof;
        n = (pairs > 0) ? pairs * 2 * cur_eff : $urandom_range(1, 3 * cur_eff);
        for (int i = 0; i < n; i++) begin
            if (i == 0) begin
                fof = (pairs > 0 || width_grew) ? 1'b1 : 1'($urandom_range(0, 1));
            end else begin
                fof = ($urandom_range(0, 99) < noise_pct);
            end
            push_pix(rand_level(), rand_level(), rand_level(), fof);
        end
    endfunction

    task automatic wait_idle();
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(bit is_write, logic [11:0] wdata, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= LINE_WIDTH_ADDR;
        pwdata <= {20'd0, wdata};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_line_width(logic [11:0] w);
        int new_eff;
        logic [31:0] rd;
        new_eff = chroma_scoreboard::eff_width(w);
        wait_idle();
        width_grew = (new_eff > cur_eff);
        cur_eff = new_eff;
        apb_access(1'b1, w, rd);
        sb.set_width(w);
        apb_access(1'b0, 12'd0, rd);
        sb.compare_field("line_width", w, rd[11:0]);
    endtask

    task automatic drive_pixels(int pause_at);
        int burst, gap, idx;
        t_pixel it;
        burst = 0;
        idx = 0;
        while (pixel_q.size() > 0) begin
            if (idx == pause_at) begin
                pix_in.valid <= 1'b0;
                @(posedge i_clk);
                while (sb.pending() != 0) @(posedge i_clk);
            end
            if (burst == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                burst = $urandom_range(1, 24);
                if (gap > 0) begin
                    pix_in.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            it = pixel_q[0];
            pix_in.valid <= 1'b1;
            pix_in.red_in <= it.red;
            pix_in.green_in <= it.green;
            pix_in.blue_in <= it.blue;
            pix_in.first_of_frame <= it.frame_start;
            do @(posedge i_clk); while (!pix_in.ready);
            void'(pixel_q.pop_front());
            burst--;
            idx++;
        end
        pix_in.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] rd;
        int phase, random_items, w, pairs, pause_at;
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        pix_in.valid <= 1'b0;
        pix_in.red_in <= '0;
        pix_in.green_in <= '0;
        pix_in.blue_in <= '0;
        pix_in.first_of_frame <= 1'b0;
        hold_req = 1'b0;
        width_grew = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_access(1'b0, 12'd0, rd);
        sb.compare_field("line_width", LINE_WIDTH_RESET, rd[11:0]);

        set_line_width(12'd2);
        push_pix(8'h00, 8'h00, 8'h00, 1'b1);
        push_pix(8'hFF, 8'hFF, 8'hFF, 1'b0);
        push_pix(8'hFF, 8'h00, 8'h00, 1'b0);
        push_pix(8'h00, 8'hFF, 8'h00, 1'b0);
        push_pix(8'h00, 8'h00, 8'hFF, 1'b0);
        push_pix(8'hFF, 8'hFF, 8'h00, 1'b0);
        push_pix(8'h00, 8'hFF, 8'hFF, 1'b0);
        push_pix(8'hFF, 8'h00, 8'hFF, 1'b0);
        drive_pixels(-1);

        // odd width: trailing column counted, never stored
        set_line_width(12'd3);
        push_pix(8'hFF, 8'h00, 8'h00, 1'b1);
        push_pix(8'h00, 8'h00, 8'hFF, 1'b0);
        push_pix(8'h80, 8'h80, 8'h80, 1'b0);
        push_pix(8'h00, 8'hFF, 8'h00, 1'b0);
        push_pix(8'hFF, 8'hFF, 8'hFF, 1'b0);
        push_pix(8'h07, 8'hC8, 8'h21, 1'b0);
        drive_pixels(-1);

        set_line_width(12'd1);
        push_pix(8'hFF, 8'hFF, 8'h00, 1'b1);
        push_pix(8'h00, 8'h00, 8'h00, 1'b0);
        push_pix(8'h80, 8'h00, 8'hFF, 1'b0);
        push_pix(8'h00, 8'h80, 8'hFF, 1'b0);
        drive_pixels(-1);

        // shrink mid-row: the next pixel closes the upper row
        set_line_width(12'd2048);
        build_frame(0, 0);
        while (pixel_q.size() > 6) void'(pixel_q.pop_back());
        drive_pixels(-1);
        set_line_width(12'd4);
        repeat (5) push_pix(rand_level(), rand_level(), rand_level(), 1'b0);
        drive_pixels(-1);

        phase = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 11))
                0: w = 0;
                1: w = 1;
                2: w = 16;
                default: w = $urandom_range(2, 10);
            endcase
            pairs = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 3);
            if (phase == 1) begin
                w = 6;
                pairs = 3;
            end
            if (phase == 2) begin
                pairs = 2;
            end
            set_line_width(w[11:0]);
            build_frame(pairs, (pairs > 0) ? 2 : 15);
            random_items += pixel_q.size();
            pause_at = (phase == 2) ? pixel_q.size() / 2 : -1;
            if (phase == 1) begin
                hold_req = 1'b1;
            end
            drive_pixels(pause_at);
            phase++;
        end

        set_line_width(12'hFFF);
        build_frame(0, 0);
        while (pixel_q.size() > 8) void'(pixel_q.pop_back());
        drive_pixels(-1);

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
